@@ rtl/core/eid_pkg.sv @@
// eid_pkg: shared types and codes for the entity ID allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package eid_pkg;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    typedef logic [1:0] func_t;
    typedef logic [1:0] status_t;

    localparam func_t FN_CREATE  = 2'd0;
    localparam func_t FN_DESTROY = 2'd1;
    localparam func_t FN_SET     = 2'd2;
    localparam func_t FN_GET     = 2'd3;

    localparam status_t STAT_OK        = 2'd0;
    localparam status_t STAT_EXHAUSTED = 2'd1;
    localparam status_t STAT_RANGE     = 2'd2;
    localparam status_t STAT_FULL      = 2'd3;

endpackage

`default_nettype wire

@@ rtl/core/eid_ram.sv @@
// eid_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module eid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/entity_id_allocator_unit.sv @@
// Entity ID allocator: free-list stack of recycled IDs plus per-ID signature store.
// Depends on eid_pkg and eid_ram.
// A transferred request moves to the EXEC state; its result is then registered with done high.
// A new request is taken only in IDLE, after EXEC (memory read at transfer, then read-modify-write).
// Reset: counters clear at once; busy stays high while the signature memory is
// swept to zero. Results cannot be stalled by the receiver.
`timescale 1ns / 1ps
`default_nettype none

module entity_id_allocator_unit #(
    parameter int NUM_IDS  = 256,
    parameter int SIG_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  func,
    input  wire logic [7:0]  entity_id,
    input  wire logic [31:0] signature_in,
    output logic             done,
    output logic [7:0]       entity_out,
    output logic [31:0]      signature_out,
    output logic [8:0]       live_count,
    output logic [1:0]       status
);

    localparam int IW = $clog2(NUM_IDS);
    localparam int CW = $clog2(NUM_IDS + 1);
    localparam logic [CW-1:0] NUM_C   = CW'(NUM_IDS);
    localparam logic [31:0]   NUM_U32 = 32'(NUM_IDS);
    localparam logic [IW-1:0] LAST_ID = IW'(NUM_IDS - 1);

    eid_pkg::state_t state_reg, state_next;

    eid_pkg::func_t func_reg;
    logic [7:0]     id_reg;
    logic [31:0]    sig_reg;

    logic [CW-1:0] depth_reg, depth_next;
    logic [CW-1:0] fresh_reg, fresh_next;
    logic [CW-1:0] live_reg, live_next;
    logic [IW-1:0] clr_reg, clr_next;

    logic               done_reg, done_next;
    logic [IW-1:0]      ent_reg, ent_next;
    logic [31:0]        sigo_reg, sigo_next;
    eid_pkg::status_t   status_reg, status_next;

    logic                sig_we;
    logic [IW-1:0]       sig_waddr;
    logic [SIG_BITS-1:0] sig_wdata;
    logic [IW-1:0]       sig_raddr;
    logic [SIG_BITS-1:0] sig_rdata;

    logic          stk_we;
    logic [IW-1:0] stk_waddr;
    logic [IW-1:0] stk_wdata;
    logic [IW-1:0] stk_raddr;
    logic [IW-1:0] stk_rdata;

    logic [IW+7:0]         in_id_wide;
    logic [IW+7:0]         reg_id_wide;
    logic [IW-1:0]         id_idx;
    logic [CW-1:0]         depth_m1;
    logic [31:0]           id_ext;
    logic                  in_range;
    logic [SIG_BITS+31:0]  sig_in_wide;
    logic [SIG_BITS+31:0]  sig_out_wide;
    logic [IW+7:0]         ent_wide;
    logic [CW+8:0]         live_wide;

    assign in_id_wide   = {{IW{1'b0}}, entity_id};
    assign reg_id_wide  = {{IW{1'b0}}, id_reg};
    assign id_idx       = reg_id_wide[IW-1:0];
    assign depth_m1     = depth_reg - CW'(1);
    assign id_ext       = {24'd0, id_reg};
    assign in_range     = (id_ext < NUM_U32);
    assign sig_in_wide  = {{SIG_BITS{1'b0}}, sig_reg};
    assign sig_out_wide = {32'd0, sig_rdata};
    assign ent_wide     = {8'd0, ent_reg};
    assign live_wide    = {9'd0, live_reg};

    assign sig_raddr = in_id_wide[IW-1:0];
    assign stk_raddr = depth_m1[IW-1:0];

    eid_ram #(
        .WIDTH (SIG_BITS),
        .DEPTH (NUM_IDS),
        .AW    (IW)
    ) u_sig_ram (
        .clk   (clk),
        .we    (sig_we),
        .waddr (sig_waddr),
        .wdata (sig_wdata),
        .raddr (sig_raddr),
        .rdata (sig_rdata)
    );

    eid_ram #(
        .WIDTH (IW),
        .DEPTH (NUM_IDS),
        .AW    (IW)
    ) u_stk_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            eid_pkg::S_CLEAR:
            begin
                if (clr_reg == LAST_ID)
                begin
                    state_next = eid_pkg::S_IDLE;
                end
            end
            eid_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = eid_pkg::S_EXEC;
                end
            end
            eid_pkg::S_EXEC:
            begin
                state_next = eid_pkg::S_IDLE;
            end
            default:
            begin
                state_next = eid_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        sig_we      = 1'b0;
        sig_waddr   = id_idx;
        sig_wdata   = sig_in_wide[SIG_BITS-1:0];
        stk_we      = 1'b0;
        stk_waddr   = depth_reg[IW-1:0];
        stk_wdata   = id_idx;
        depth_next  = depth_reg;
        fresh_next  = fresh_reg;
        live_next   = live_reg;
        clr_next    = clr_reg;
        done_next   = 1'b0;
        ent_next    = id_idx;
        sigo_next   = 32'd0;
        status_next = eid_pkg::STAT_OK;
        unique case (state_reg)
            eid_pkg::S_CLEAR:
            begin
                sig_we    = 1'b1;
                sig_waddr = clr_reg;
                sig_wdata = '0;
                clr_next  = clr_reg + IW'(1);
            end
            eid_pkg::S_IDLE:
            begin
            end
            eid_pkg::S_EXEC:
            begin
                done_next = 1'b1;
                if (func_reg == eid_pkg::FN_CREATE)
                begin
                    ent_next = '0;
                    if (live_reg >= NUM_C)
                    begin
                        status_next = eid_pkg::STAT_EXHAUSTED;
                    end
                    else if (depth_reg != '0)
                    begin
                        depth_next = depth_m1;
                        ent_next   = stk_rdata;
                        live_next  = live_reg + CW'(1);
                    end
                    else if (fresh_reg < NUM_C)
                    begin
                        ent_next   = fresh_reg[IW-1:0];
                        fresh_next = fresh_reg + CW'(1);
                        live_next  = live_reg + CW'(1);
                    end
                    else
                    begin
                        status_next = eid_pkg::STAT_EXHAUSTED;
                    end
                end
                else if (!in_range)
                begin
                    status_next = eid_pkg::STAT_RANGE;
                end
                else
                begin
                    unique case (func_reg)
                        eid_pkg::FN_DESTROY:
                        begin
                            if (depth_reg >= NUM_C)
                            begin
                                status_next = eid_pkg::STAT_FULL;
                            end
                            else
                            begin
                                sig_we     = 1'b1;
                                sig_wdata  = '0;
                                stk_we     = 1'b1;
                                depth_next = depth_reg + CW'(1);
                                if (live_reg != '0)
                                begin
                                    live_next = live_reg - CW'(1);
                                end
                            end
                        end
                        eid_pkg::FN_SET:
                        begin
                            sig_we = 1'b1;
                        end
                        eid_pkg::FN_GET:
                        begin
                            sigo_next = sig_out_wide[31:0];
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= eid_pkg::S_CLEAR;
            depth_reg <= '0;
            fresh_reg <= '0;
            live_reg  <= '0;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            fresh_reg <= fresh_next;
            live_reg  <= live_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == eid_pkg::S_IDLE && start)
        begin
            func_reg <= func;
            id_reg   <= entity_id;
            sig_reg  <= signature_in;
        end
        ent_reg    <= ent_next;
        sigo_reg   <= sigo_next;
        status_reg <= status_next;
    end

    assign busy          = (state_reg != eid_pkg::S_IDLE);
    assign done          = done_reg;
    assign entity_out    = ent_wide[7:0];
    assign signature_out = sigo_reg;
    assign live_count    = live_wide[8:0];
    assign status        = status_reg;

endmodule

`default_nettype wire

@@ tb/entity_id_allocator_unit_tb.sv @@
// Self-checking testbench for entity_id_allocator_unit: directed table, then random
// create/destroy/set/get traffic checked against an in-bench model of the ID pool.
// Depends on eid_pkg and the allocator RTL.
`timescale 1ns / 1ps

module entity_id_allocator_unit_tb;

    localparam int NUM_IDS        = 256;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int FILL_LEN       = 262;
    localparam int DRAIN_LEN      = 262;

    typedef struct packed {
        logic [7:0]       ent;
        logic [31:0]      sig;
        logic [8:0]       live;
        eid_pkg::status_t st;
    } alloc_result_t;

    typedef struct packed {
        eid_pkg::func_t f;
        logic [7:0]     id;
        logic [31:0]    sig;
        logic           pin;
        alloc_result_t  res;
    } request_row_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    eid_pkg::func_t   func;
    logic [7:0]       entity_id;
    logic [31:0]      signature_in;
    logic             done;
    logic [7:0]       entity_out;
    logic [31:0]      signature_out;
    logic [8:0]       live_count;
    eid_pkg::status_t status;

    // typed expectation travelling alongside a directed request
    logic          pinned;
    alloc_result_t pinned_res;

    // model of the pool
    logic [7:0]  free_stack [NUM_IDS];
    logic [31:0] sig_store  [NUM_IDS];
    int          free_depth;
    int          fresh_id;
    int          live_ids;

    // expected results in transfer order
    alloc_result_t pend_buf [16];
    logic [3:0]    pend_rd;
    logic [3:0]    pend_wr;
    int            pend_count;

    alloc_result_t predicted;
    alloc_result_t oldest;
    int            failures;
    int            quiet_cycles;

    request_row_t directed_rows [22];

    entity_id_allocator_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .entity_id    (entity_id),
        .signature_in (signature_in),
        .done         (done),
        .entity_out   (entity_out),
        .signature_out(signature_out),
        .live_count   (live_count),
        .status       (status)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic alloc_result_t apply_request(eid_pkg::func_t f, logic [7:0] id,
                                                     logic [31:0] sig);
        alloc_result_t r;
        r.ent  = id;
        r.sig  = '0;
        r.st   = eid_pkg::STAT_OK;
        if (f == eid_pkg::FN_CREATE)
        begin
            r.ent = '0;
            if (live_ids >= NUM_IDS)
                r.st = eid_pkg::STAT_EXHAUSTED;
            else if (free_depth > 0)
            begin
                free_depth--;
                r.ent = free_stack[free_depth];
                live_ids++;
            end
            else if (fresh_id < NUM_IDS)
            begin
                r.ent = fresh_id[7:0];
                fresh_id++;
                live_ids++;
            end
            else
                r.st = eid_pkg::STAT_EXHAUSTED;
        end
        else if (int'(id) >= NUM_IDS)
            r.st = eid_pkg::STAT_RANGE;
        else if (f == eid_pkg::FN_DESTROY)
        begin
            if (free_depth >= NUM_IDS)
                r.st = eid_pkg::STAT_FULL;
            else
            begin
                sig_store[id] = '0;
                free_stack[free_depth] = id;
                free_depth++;
                if (live_ids > 0)
                    live_ids--;
            end
        end
        else if (f == eid_pkg::FN_SET)
            sig_store[id] = sig;
        else
            r.sig = sig_store[id];
        r.live = live_ids[8:0];
        return r;
    endfunction

    function automatic request_row_t req(eid_pkg::func_t f, logic [7:0] id,
                                         logic [31:0] sig);
        request_row_t row;
        row.f   = f;
        row.id  = id;
        row.sig = sig;
        row.pin = 1'b0;
        row.res = '0;
        return row;
    endfunction

    function automatic request_row_t req_exp(eid_pkg::func_t f, logic [7:0] id,
                                             logic [31:0] sig,
                                             logic [7:0] ent, logic [31:0] sout,
                                             logic [8:0] live, eid_pkg::status_t st);
        request_row_t row;
        row          = req(f, id, sig);
        row.pin      = 1'b1;
        row.res.ent  = ent;
        row.res.sig  = sout;
        row.res.live = live;
        row.res.st   = st;
        return row;
    endfunction

    function automatic logic [7:0] pick_id();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(0, 15));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [31:0] pick_sig();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            failures++;
        end
    endtask

    // called just after a rising edge; returns at the edge where the transfer happens
    task automatic issue(request_row_t row);
        start        <= 1'b1;
        func         <= row.f;
        entity_id    <= row.id;
        signature_in <= row.sig;
        pinned       <= row.pin;
        pinned_res   <= row.res;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic idle_for(int n);
        if (n > 0)
        begin
            start        <= 1'b0;
            signature_in <= $urandom;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic run_mixed(int n);
        int             r;
        eid_pkg::func_t f;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
                f = eid_pkg::FN_CREATE;
            else if (r < 55)
                f = eid_pkg::FN_DESTROY;
            else if (r < 80)
                f = eid_pkg::FN_SET;
            else
                f = eid_pkg::FN_GET;
            issue(req(f, pick_id(), pick_sig()));
            idle_for(gap_len());
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            quiet_cycles = quiet_cycles + 1;
            if (done)
            begin
                quiet_cycles = 0;
                if (pend_count == 0)
                begin
                    $error("result with no request outstanding: entity_out 0x%0h",
                           entity_out);
                    failures++;
                end
                else
                begin
                    oldest     = pend_buf[pend_rd];
                    pend_rd    = pend_rd + 4'd1;
                    pend_count = pend_count - 1;
                    check_field("entity_out", 32'(oldest.ent), 32'(entity_out));
                    check_field("signature_out", oldest.sig, signature_out);
                    check_field("live_count", 32'(oldest.live), 32'(live_count));
                    check_field("status", 32'(oldest.st), 32'(status));
                end
            end
            if (start && !busy)
            begin
                quiet_cycles      = 0;
                predicted         = apply_request(func, entity_id, signature_in);
                pend_buf[pend_wr] = pinned ? pinned_res : predicted;
                pend_wr           = pend_wr + 4'd1;
                pend_count        = pend_count + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        failures     = 0;
        quiet_cycles = 0;
        free_depth   = 0;
        fresh_id     = 0;
        live_ids     = 0;
        pend_rd      = '0;
        pend_wr      = '0;
        pend_count   = 0;
        foreach (sig_store[i])
        begin
            sig_store[i]  = '0;
            free_stack[i] = '0;
        end

        directed_rows = '{
            req_exp(eid_pkg::FN_GET,     8'd0,   32'h1234_5678, 8'd0,   32'h0,
                    9'd0, eid_pkg::STAT_OK),
            req_exp(eid_pkg::FN_GET,     8'd255, 32'h0,         8'd255, 32'h0,
                    9'd0, eid_pkg::STAT_OK),
            req_exp(eid_pkg::FN_CREATE,  8'd77,  32'hFFFF_FFFF, 8'd0,   32'h0,
                    9'd1, eid_pkg::STAT_OK),
            req_exp(eid_pkg::FN_CREATE,  8'd255, 32'h0,         8'd1,   32'h0,
                    9'd2, eid_pkg::STAT_OK),
            req_exp(eid_pkg::FN_SET,     8'd1,   32'hFFFF_FFFF, 8'd1,   32'h0,
                    9'd2, eid_pkg::STAT_OK),
            req_exp(eid_pkg::FN_GET,     8'd1,   32'h0,         8'd1,   32'hFFFF_FFFF,
                    9'd2, eid_pkg::STAT_OK),
            req_exp(eid_pkg::FN_SET,     8'd255, 32'hA5A5_A5A5, 8'd255, 32'h0,
                    9'd2, eid_pkg::STAT_OK),
            req(eid_pkg::FN_GET,     8'd255, 32'h0),
            req(eid_pkg::FN_SET,     8'd0,   32'h0),
            req_exp(eid_pkg::FN_DESTROY, 8'd1,   32'hFFFF_FFFF, 8'd1,   32'h0,
                    9'd1, eid_pkg::STAT_OK),
            req_exp(eid_pkg::FN_GET,     8'd1,   32'h0,         8'd1,   32'h0,
                    9'd1, eid_pkg::STAT_OK),
            req(eid_pkg::FN_CREATE,  8'd0,   32'h0),
            req(eid_pkg::FN_DESTROY, 8'd200, 32'h0),
            req(eid_pkg::FN_DESTROY, 8'd0,   32'h0),
            req_exp(eid_pkg::FN_DESTROY, 8'd0,   32'h0,         8'd0,   32'h0,
                    9'd0, eid_pkg::STAT_OK),
            req(eid_pkg::FN_CREATE,  8'd0,   32'h0),
            req(eid_pkg::FN_CREATE,  8'd0,   32'h0),
            req(eid_pkg::FN_CREATE,  8'd0,   32'h0),
            req(eid_pkg::FN_CREATE,  8'd0,   32'h0),
            req(eid_pkg::FN_SET,     8'd128, 32'h5A5A_5A5A),
            req(eid_pkg::FN_GET,     8'd128, 32'h0),
            req(eid_pkg::FN_GET,     8'd127, 32'h0)
        };

        rst_n        <= 1'b0;
        start        <= 1'b0;
        func         <= eid_pkg::FN_CREATE;
        entity_id    <= '0;
        signature_in <= '0;
        pinned       <= 1'b0;
        pinned_res   <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            issue(directed_rows[i]);
            idle_for(gap_len());
        end

        run_mixed(300);

        // run the pool dry, back to back
        for (int i = 0; i < FILL_LEN; i++)
            issue(req(eid_pkg::FN_CREATE, pick_id(), pick_sig()));

        run_mixed(200);

        // let the pipeline empty before refilling the free stack
        idle_for(1);
        while (pend_count != 0)
            @(posedge clk);

        for (int i = 0; i < DRAIN_LEN; i++)
        begin
            issue(req(eid_pkg::FN_DESTROY, 8'($urandom_range(0, 255)), pick_sig()));
            idle_for(gap_len());
        end

        run_mixed(480);

        idle_for(1);
        while (pend_count != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
